### rtl/core/buzzer_alert_pattern_sequencer_top_defines.svh
// assertion macros for the buzzer alert pattern sequencer
`ifndef BUZZER_ALERT_PATTERN_SEQUENCER_TOP_DEFINES_SVH
`define BUZZER_ALERT_PATTERN_SEQUENCER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define BAPSEQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bapseq assertion failed");

// antecedent implies consequent in the next cycle
`define BAPSEQ_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bapseq assertion failed");

`else

`define BAPSEQ_ASSERT_IMP(label, clk, rst, ante, cons)
`define BAPSEQ_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/core/bapseq_pkg.sv
package bapseq_pkg;

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_PLAY = 2'd1,
      OP_MUTE = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      PAT_SILENCE = 3'd0,
      PAT_SHORT   = 3'd1,
      PAT_LONG    = 3'd2,
      PAT_DOUBLE  = 3'd3,
      PAT_ALARM   = 3'd4,
      PAT_SIREN   = 3'd5
   } pattern_type;

   localparam logic [9:0] ELAPSED_MAX  = 10'd1023;
   localparam logic [9:0] SHORT_TICKS  = 10'd100;
   localparam logic [9:0] LONG_TICKS   = 10'd600;
   localparam logic [9:0] DOUBLE_TICKS = 10'd80;
   localparam logic [9:0] ALARM_ON     = 10'd100;
   localparam logic [9:0] ALARM_GAP    = 10'd800;
   localparam logic [9:0] SIREN_HALF   = 10'd400;

   localparam logic [10:0] HZ_BEEP     = 11'd2000;
   localparam logic [10:0] HZ_LONG     = 11'd1200;
   localparam logic [10:0] HZ_SIREN_LO = 11'd800;
   localparam logic [10:0] HZ_SIREN_HI = 11'd1500;

   typedef struct packed {
      logic [1:0] opcode;
      logic [2:0] pattern;
      logic       mute_value;
   } item_type;

   typedef struct packed {
      logic        tone_on;
      logic [10:0] tone_hz;
      logic [2:0]  pattern_now;
      logic        muted_now;
   } result_type;

endpackage

### rtl/core/bapseq_in_stage.sv
module bapseq_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  bapseq_pkg::item_type req_item,
   input  logic               advance,
   output logic               item_valid,
   output bapseq_pkg::item_type item
);
   import bapseq_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take;

   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      valid_in = take ? 1'b1 : (advance ? 1'b0 : valid_ff);
      item_in  = take ? req_item : item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### rtl/core/bapseq_engine.sv
module bapseq_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  bapseq_pkg::item_type  item,
   output bapseq_pkg::result_type result
);
   import bapseq_pkg::*;

   pattern_type pat_ff, pat_in;
   logic [1:0]  step_ff, step_in;
   logic [9:0]  elapsed_ff, elapsed_in;
   logic        mute_ff, mute_in;
   logic [9:0]  e_inc;
   logic        play_ok;

   always_comb begin
      pat_in     = pat_ff;
      step_in    = step_ff;
      elapsed_in = elapsed_ff;
      mute_in    = mute_ff;
      e_inc      = (elapsed_ff < ELAPSED_MAX) ? elapsed_ff + 10'd1 : elapsed_ff;
      play_ok    = (item.pattern <= 3'(PAT_SIREN)) &&
                   !(mute_ff && item.pattern != 3'(PAT_SIREN) &&
                     item.pattern != 3'(PAT_SILENCE));
      unique case (opcode_type'(item.opcode))
         OP_TICK: begin
            if (pat_ff != PAT_SILENCE) begin
               elapsed_in = e_inc;
               case (pat_ff)
                  PAT_SHORT: begin
                     if (step_ff == 2'd0 && e_inc >= SHORT_TICKS) begin
                        pat_in     = PAT_SILENCE;
                        step_in    = 2'd0;
                        elapsed_in = '0;
                     end
                  end
                  PAT_LONG: begin
                     if (step_ff == 2'd0 && e_inc >= LONG_TICKS) begin
                        pat_in     = PAT_SILENCE;
                        step_in    = 2'd0;
                        elapsed_in = '0;
                     end
                  end
                  PAT_DOUBLE: begin
                     if (e_inc >= DOUBLE_TICKS && step_ff != 2'd3) begin
                        elapsed_in = '0;
                        if (step_ff == 2'd2) begin
                           pat_in  = PAT_SILENCE;
                           step_in = 2'd0;
                        end else begin
                           step_in = step_ff + 2'd1;
                        end
                     end
                  end
                  PAT_ALARM: begin
                     if (step_ff != 2'd3 && e_inc >= ALARM_ON) begin
                        step_in    = step_ff + 2'd1;
                        elapsed_in = '0;
                     end else if (step_ff == 2'd3 && e_inc >= ALARM_GAP) begin
                        step_in    = 2'd0;
                        elapsed_in = '0;
                     end
                  end
                  PAT_SIREN: begin
                     if (e_inc >= SIREN_HALF) begin
                        step_in    = (step_ff == 2'd0) ? 2'd1 : 2'd0;
                        elapsed_in = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         OP_PLAY: begin
            if (play_ok) begin
               pat_in     = pattern_type'(item.pattern);
               step_in    = 2'd0;
               elapsed_in = '0;
            end
         end
         OP_MUTE: begin
            mute_in = item.mute_value;
            if (item.mute_value && pat_ff != PAT_SIREN) begin
               pat_in     = PAT_SILENCE;
               step_in    = 2'd0;
               elapsed_in = '0;
            end
         end
         default: ;
      endcase
   end

   // tone from the state after this transfer
   always_comb begin
      result.tone_on     = 1'b0;
      result.tone_hz     = '0;
      result.pattern_now = pat_in;
      result.muted_now   = mute_in;
      case (pat_in)
         PAT_SHORT: begin
            if (step_in == 2'd0) begin
               result.tone_on = 1'b1;
               result.tone_hz = HZ_BEEP;
            end
         end
         PAT_LONG: begin
            if (step_in == 2'd0) begin
               result.tone_on = 1'b1;
               result.tone_hz = HZ_LONG;
            end
         end
         PAT_DOUBLE, PAT_ALARM: begin
            if (step_in == 2'd0 || step_in == 2'd2) begin
               result.tone_on = 1'b1;
               result.tone_hz = HZ_BEEP;
            end
         end
         PAT_SIREN: begin
            result.tone_on = 1'b1;
            result.tone_hz = (step_in == 2'd0) ? HZ_SIREN_LO : HZ_SIREN_HI;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff     <= PAT_SILENCE;
         step_ff    <= 2'd0;
         elapsed_ff <= '0;
         mute_ff    <= 1'b0;
      end else if (fire) begin
         pat_ff     <= pat_in;
         step_ff    <= step_in;
         elapsed_ff <= elapsed_in;
         mute_ff    <= mute_in;
      end
   end

endmodule

### rtl/core/buzzer_alert_pattern_sequencer_top.sv
// Buzzer alert pattern sequencer.
// Input channel req_*: one transfer per item carrying req_opcode (tick,
// play pattern, set mute), req_pattern and req_mute_value.
// Result channel rsp_*: exactly one transfer per input item, in order,
// giving the tone on/off, tone frequency, active pattern and mute flag.
// A transfer happens at a clock edge with valid high and stall low.
// Flow: an item accepted at an edge is registered in the input stage and
// is processed against the pattern state at the edge on which it advances,
// which also loads its result into the result register driving rsp_*.
// Throughput: one item per cycle unless the receiver stalls; the pattern
// state updates through short compare logic between the two registers.
// When the receiver stalls, the result register holds its payload and the
// input register can still take one more item; req_stall rises only when
// both are full and rsp_stall is high.
// Reset (synchronous, active high) empties both registers and returns the
// state to silence, step 0, elapsed 0, not muted.
`include "buzzer_alert_pattern_sequencer_top_defines.svh"

module buzzer_alert_pattern_sequencer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [2:0]  req_pattern,
   input  logic        req_mute_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_tone_on,
   output logic [10:0] rsp_tone_hz,
   output logic [2:0]  rsp_pattern_now,
   output logic        rsp_muted_now
);
   import bapseq_pkg::*;

   item_type   req_item, item;
   logic       item_valid;
   logic       advance;
   result_type result;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   assign req_item.opcode     = req_opcode;
   assign req_item.pattern    = req_pattern;
   assign req_item.mute_value = req_mute_value;

   assign advance = item_valid && (!rsp_valid_ff || !rsp_stall);

   bapseq_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   bapseq_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item),
      .result (result)
   );

   always_comb begin
      rsp_valid_in = advance ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
      rsp_in       = advance ? result : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tone_on     = rsp_ff.tone_on;
   assign rsp_tone_hz     = rsp_ff.tone_hz;
   assign rsp_pattern_now = rsp_ff.pattern_now;
   assign rsp_muted_now   = rsp_ff.muted_now;

   `BAPSEQ_ASSERT_NXT(a_advance_gives_rsp, clock, reset, advance, rsp_valid_ff)
   `BAPSEQ_ASSERT_IMP(a_tone_consistent, clock, reset, rsp_valid_ff, rsp_ff.tone_on == (rsp_ff.tone_hz != 11'd0))
   `BAPSEQ_ASSERT_IMP(a_muted_pattern, clock, reset, rsp_valid_ff && rsp_ff.muted_now, rsp_ff.pattern_now == 3'(PAT_SILENCE) || rsp_ff.pattern_now == 3'(PAT_SIREN))
   `BAPSEQ_ASSERT_IMP(a_hz_legal, clock, reset, rsp_valid_ff, rsp_ff.tone_hz == 11'd0 || rsp_ff.tone_hz == HZ_BEEP || rsp_ff.tone_hz == HZ_LONG || rsp_ff.tone_hz == HZ_SIREN_LO || rsp_ff.tone_hz == HZ_SIREN_HI)

endmodule

### bench/bapseq_tone_check.sv
module bapseq_tone_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [2:0]  req_pattern,
   input  logic        req_mute_value,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_tone_on,
   input  logic [10:0] rsp_tone_hz,
   input  logic [2:0]  rsp_pattern_now,
   input  logic        rsp_muted_now,
   output int          failures,
   output int          pending,
   output int          checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import bapseq_pkg::*;

   logic [2:0] cur_pattern;
   logic [1:0] cur_step;
   logic [9:0] cur_elapsed;
   logic       cur_muted;

   result_type expected_tones[$];

   function automatic void start_from(logic [2:0] p);
      cur_pattern = p;
      cur_step    = 2'd0;
      cur_elapsed = 10'd0;
   endfunction

   function automatic void go_step(logic [1:0] s);
      cur_step    = s;
      cur_elapsed = 10'd0;
   endfunction

   function automatic result_type predict_tone(logic [1:0] op, logic [2:0] pat, logic mv);
      result_type r;
      if (op == OP_TICK) begin
         if (cur_pattern != PAT_SILENCE) begin
            if (cur_elapsed < ELAPSED_MAX) cur_elapsed = cur_elapsed + 10'd1;
            case (cur_pattern)
               PAT_SHORT: begin
                  if (cur_step == 2'd0 && cur_elapsed >= SHORT_TICKS) start_from(PAT_SILENCE);
               end
               PAT_LONG: begin
                  if (cur_step == 2'd0 && cur_elapsed >= LONG_TICKS) start_from(PAT_SILENCE);
               end
               PAT_DOUBLE: begin
                  if (cur_elapsed >= DOUBLE_TICKS) begin
                     if (cur_step == 2'd0) go_step(2'd1);
                     else if (cur_step == 2'd1) go_step(2'd2);
                     else if (cur_step == 2'd2) start_from(PAT_SILENCE);
                  end
               end
               PAT_ALARM: begin
                  if (cur_step <= 2'd2 && cur_elapsed >= ALARM_ON) go_step(cur_step + 2'd1);
                  else if (cur_step == 2'd3 && cur_elapsed >= ALARM_GAP) go_step(2'd0);
               end
               PAT_SIREN: begin
                  if (cur_elapsed >= SIREN_HALF) go_step(cur_step == 2'd0 ? 2'd1 : 2'd0);
               end
               default: ;
            endcase
         end
      end else if (op == OP_PLAY) begin
         if (pat <= PAT_SIREN &&
             !(cur_muted && pat != PAT_SIREN && pat != PAT_SILENCE))
            start_from(pat);
      end else if (op == OP_MUTE) begin
         cur_muted = mv;
         if (mv && cur_pattern != PAT_SIREN) start_from(PAT_SILENCE);
      end

      r.tone_on = 1'b0;
      r.tone_hz = 11'd0;
      if ((cur_pattern == PAT_SHORT && cur_step == 2'd0) ||
          ((cur_pattern == PAT_DOUBLE || cur_pattern == PAT_ALARM) &&
           (cur_step == 2'd0 || cur_step == 2'd2))) begin
         r.tone_on = 1'b1;
         r.tone_hz = HZ_BEEP;
      end else if (cur_pattern == PAT_LONG && cur_step == 2'd0) begin
         r.tone_on = 1'b1;
         r.tone_hz = HZ_LONG;
      end else if (cur_pattern == PAT_SIREN) begin
         r.tone_on = 1'b1;
         r.tone_hz = (cur_step == 2'd0) ? HZ_SIREN_LO : HZ_SIREN_HI;
      end
      r.pattern_now = cur_pattern;
      r.muted_now   = cur_muted;
      return r;
   endfunction

   function automatic void check_field(string name, logic [10:0] want, logic [10:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         expected_tones.delete();
         cur_pattern = PAT_SILENCE;
         cur_step    = 2'd0;
         cur_elapsed = 10'd0;
         cur_muted   = 1'b0;
         failures    = 0;
         checked     = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_tones.size() == 0) begin
               $error("result transfer with no item outstanding");
               failures++;
            end else begin
               want = expected_tones.pop_front();
               check_field("tone_on", 11'(want.tone_on), 11'(rsp_tone_on));
               check_field("tone_hz", want.tone_hz, rsp_tone_hz);
               check_field("pattern_now", 11'(want.pattern_now), 11'(rsp_pattern_now));
               check_field("muted_now", 11'(want.muted_now), 11'(rsp_muted_now));
               checked++;
            end
         end
         if (req_valid && !req_stall)
            expected_tones.push_back(predict_tone(req_opcode, req_pattern, req_mute_value));
      end
      pending = expected_tones.size();
   end

endmodule

### bench/tb_buzzer_alert_pattern_sequencer_top.sv
module tb_buzzer_alert_pattern_sequencer_top;
   import bapseq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FIRST_MIX_ITEMS = 150;
   localparam int TOTAL_ITEMS     = 1900;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode     = 2'd0;
   logic [2:0]  req_pattern    = 3'd0;
   logic        req_mute_value = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic        rsp_tone_on;
   logic [10:0] rsp_tone_hz;
   logic [2:0]  rsp_pattern_now;
   logic        rsp_muted_now;

   int failures;
   int pending;
   int checked;
   int items_sent         = 0;
   int req_idle_pct       = 18;
   int rsp_idle_pct       = 63;
   int cycles_since_reset = 0;

   always #4 clock = ~clock;

   buzzer_alert_pattern_sequencer_top uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_pattern     (req_pattern),
      .req_mute_value  (req_mute_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_tone_on     (rsp_tone_on),
      .rsp_tone_hz     (rsp_tone_hz),
      .rsp_pattern_now (rsp_pattern_now),
      .rsp_muted_now   (rsp_muted_now)
   );

   bapseq_tone_check tone_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_pattern     (req_pattern),
      .req_mute_value  (req_mute_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_tone_on     (rsp_tone_on),
      .rsp_tone_hz     (rsp_tone_hz),
      .rsp_pattern_now (rsp_pattern_now),
      .rsp_muted_now   (rsp_muted_now),
      .failures        (failures),
      .pending         (pending),
      .checked         (checked)
   );

   // long receiver hold-off early in the first mix so the block backs up
   always @(posedge clock) begin
      if (!reset) cycles_since_reset++;
      if (cycles_since_reset >= 300 && cycles_since_reset < 700)
         rsp_stall <= 1'b1;
      else
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   task automatic send_item(input logic [1:0] op, input logic [2:0] pat, input logic mv);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_pattern    <= pat;
      req_mute_value <= mv;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_noise();
      send_item(2'($urandom_range(3)), 3'($urandom_range(7)), 1'($urandom_range(1)));
   endtask

   task automatic tick_run(input int n, input int noise_pct);
      repeat (n) begin
         if ($urandom_range(99) < noise_pct) send_noise();
         else send_item(OP_TICK, 3'($urandom_range(7)), 1'($urandom_range(1)));
      end
   endtask

   task automatic random_sequence();
      int kind;
      int len_pick;
      logic [2:0] pat;
      kind = $urandom_range(99);
      if (kind < 15) begin
         repeat ($urandom_range(1, 8)) send_noise();
      end else begin
         if ($urandom_range(3) == 0)
            send_item(OP_MUTE, 3'($urandom_range(7)), 1'($urandom_range(1)));
         pat = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 5));
         send_item(OP_PLAY, pat, 1'($urandom_range(1)));
         len_pick = $urandom_range(99);
         if (len_pick < 60) tick_run($urandom_range(1, 30), 3);
         else if (len_pick < 85) tick_run($urandom_range(60, 130), 3);
         else tick_run($urandom_range(150, 450), 3);
      end
   endtask

   task automatic directed_items();
      send_item(OP_TICK, 3'd7, 1'b1);
      send_item(OP_PLAY, PAT_SILENCE, 1'b0);
      send_item(OP_PLAY, PAT_SHORT, 1'b0);
      send_item(OP_PLAY, PAT_SHORT, 1'b1);
      send_item(OP_PLAY, 3'd6, 1'b0);
      send_item(OP_PLAY, 3'd7, 1'b1);
      send_item(2'd3, 3'd7, 1'b1);
      send_item(OP_PLAY, PAT_LONG, 1'b0);
      send_item(OP_PLAY, PAT_DOUBLE, 1'b0);
      send_item(OP_PLAY, PAT_ALARM, 1'b0);
      send_item(OP_PLAY, PAT_SIREN, 1'b0);
      send_item(OP_MUTE, 3'd0, 1'b1);
      send_item(OP_PLAY, PAT_SHORT, 1'b0);
      send_item(OP_PLAY, PAT_ALARM, 1'b0);
      send_item(OP_PLAY, PAT_SILENCE, 1'b0);
      send_item(OP_PLAY, PAT_SIREN, 1'b0);
      send_item(OP_MUTE, 3'd7, 1'b0);
      send_item(OP_PLAY, PAT_LONG, 1'b0);
      send_item(OP_MUTE, 3'd0, 1'b1);
      send_item(OP_MUTE, 3'd0, 1'b1);
      send_item(OP_MUTE, 3'd0, 1'b0);
      send_item(OP_TICK, 3'd0, 1'b0);
   endtask

   initial begin
      #2ms;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin req_idle_pct = 18; rsp_idle_pct = 63; end
            1: begin req_idle_pct = 63; rsp_idle_pct = 18; end
            default: begin req_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         if (phase == 0) begin
            directed_items();
            while (items_sent < FIRST_MIX_ITEMS) random_sequence();
         end else if (phase == 1) begin
            send_item(OP_PLAY, PAT_LONG, 1'b0);
            tick_run(601, 0);
         end else begin
            send_item(OP_PLAY, PAT_ALARM, 1'b0);
            tick_run(1101, 0);
            while (items_sent < TOTAL_ITEMS) random_sequence();
         end
      end
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d item transfers under three stall mixes and a long receiver hold-off",
               items_sent);
      $display("%0d results compared against the predicted tone sequence", checked);
      if (failures == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         if (pending != 0) $error("%0d predicted results never arrived", pending);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
